// ===== design/sorted_transmit_job_queue_assert.svh =====
// Assertion macros for the sorted transmit job queue.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef SORTED_TRANSMIT_JOB_QUEUE_ASSERT_SVH
`define SORTED_TRANSMIT_JOB_QUEUE_ASSERT_SVH
`ifndef ASSERT_OFF
`define STJQ_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define STJQ_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define STJQ_ASSERT_IMP(label, ante, cons, msg)
`define STJQ_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ===== design/stjq_pkg.sv =====
// Types and codes shared by the sorted transmit job queue.
// No dependencies.
package stjq_pkg;

	localparam int unsigned IN_DATA_W  = 152;
	localparam int unsigned OUT_DATA_W = 160;
	localparam int unsigned OCC_W      = 5;

	typedef enum logic [1:0] {
		CMD_ENQUEUE = 2'd0,
		CMD_DEQUEUE = 2'd1,
		CMD_PEEK    = 2'd2,
		CMD_CLEAR   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_DONE  = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic [31:0] tx_counter;
		logic [7:0]  length;
		logic [7:0]  coderate;
		logic [31:0] datarate;
		logic [7:0]  bandwidth;
		logic [31:0] frequency;
		logic [31:0] release_time;
	} job_t;

	typedef struct packed {
		logic insert;
		logic remove;
	} cell_ctrl_t;

endpackage

// ===== design/stjq_cell.sv =====
// One slot of the sorted job chain: holds a job and shifts it to a neighbor.
// Depends on stjq_pkg.
module stjq_cell import stjq_pkg::*; #(
	parameter int unsigned INDEX = 0,
	parameter int unsigned CNT_W = 5
) (
	input  logic             clk,
	input  cell_ctrl_t       ctrl,
	input  job_t             new_job,
	input  logic [CNT_W-1:0] count,
	input  job_t             left_job,
	input  logic             left_place,
	input  job_t             right_job,
	output job_t             job_q,
	output logic             place
);

	logic occupied;

	// A slot at or after the insertion point holds a later job or is free.
	assign occupied = count > CNT_W'(INDEX);
	assign place    = !occupied || (job_q.release_time > new_job.release_time);

	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (left_place) begin
				job_q <= left_job;
			end else if (place) begin
				job_q <= new_job;
			end
		end else if (ctrl.remove) begin
			job_q <= right_job;
		end
	end

endmodule

// ===== design/sorted_transmit_job_queue.sv =====
// Sorted transmit job queue: a chain of slots kept in ascending release time.
// A result is registered and appears in the cycle after its command transaction is taken.
// Throughput: one command per cycle unless m_tready stalls the output; all slots compare and shift in parallel.
// The output register frees the input side as soon as its result is taken.
// Reset clears the job count and output valid; slot contents need no clearing.
module sorted_transmit_job_queue import stjq_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// release_time, frequency, bandwidth, datarate, coderate, length, tx_counter
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// command
	input  logic [1:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// release_time, frequency, bandwidth, datarate, coderate, length, tx_counter,
	// occupancy, zero fill
	output logic [OUT_DATA_W-1:0] m_tdata,
	// status
	output logic [1:0]            m_tuser
);

`include "sorted_transmit_job_queue_assert.svh"

	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_next;
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	status_t               m_status_q;

	job_t       new_job;
	cmd_t       cmd;
	cell_ctrl_t ctrl;
	logic       accept;
	logic       full;
	logic       empty;
	logic       report;
	status_t    status;
	job_t       out_job;

	job_t slot_job [QUEUE_DEPTH];
	logic slot_place [QUEUE_DEPTH];

	assign new_job.release_time = s_tdata[31:0];
	assign new_job.frequency    = s_tdata[63:32];
	assign new_job.bandwidth    = s_tdata[71:64];
	assign new_job.datarate     = s_tdata[103:72];
	assign new_job.coderate     = s_tdata[111:104];
	assign new_job.length       = s_tdata[119:112];
	assign new_job.tx_counter   = s_tdata[151:120];
	assign cmd                  = cmd_t'(s_tuser);

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign full     = count_q == CNT_W'(QUEUE_DEPTH);
	assign empty    = count_q == '0;

	always_comb begin
		status      = STATUS_DONE;
		report      = 1'b0;
		ctrl        = '0;
		count_next  = count_q;
		unique case (cmd)
			CMD_ENQUEUE: begin
				if (full) begin
					status = STATUS_FULL;
				end else begin
					ctrl.insert = accept;
					count_next  = count_q + CNT_W'(1);
				end
			end
			CMD_DEQUEUE: begin
				if (empty) begin
					status = STATUS_EMPTY;
				end else begin
					report      = 1'b1;
					ctrl.remove = accept;
					count_next  = count_q - CNT_W'(1);
				end
			end
			CMD_PEEK: begin
				if (empty) begin
					status = STATUS_EMPTY;
				end else begin
					report = 1'b1;
				end
			end
			CMD_CLEAR: begin
				count_next = '0;
			end
			default: begin
				count_next = count_q;
			end
		endcase
	end

	assign out_job = report ? slot_job[0] : '0;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
		job_t left_job;
		logic left_place;
		job_t right_job;

		if (i == 0) begin : g_head
			assign left_job   = new_job;
			assign left_place = 1'b0;
		end else begin : g_body
			assign left_job   = slot_job[i-1];
			assign left_place = slot_place[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign right_job = slot_job[i];
		end else begin : g_inner
			assign right_job = slot_job[i+1];
		end

		stjq_cell #(
			.INDEX (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.new_job    (new_job),
			.count      (count_q),
			.left_job   (left_job),
			.left_place (left_place),
			.right_job  (right_job),
			.job_q      (slot_job[i]),
			.place      (slot_place[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_next;
			end
			if (s_tready) begin
				m_tvalid_q <= s_tvalid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_status_q <= status;
			m_tdata_q  <= {3'b000, OCC_W'(count_next), out_job.tx_counter, out_job.length,
				out_job.coderate, out_job.datarate, out_job.bandwidth, out_job.frequency,
				out_job.release_time};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_status_q;

	`STJQ_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(QUEUE_DEPTH),
		"job count exceeds queue depth")
	`STJQ_ASSERT_IMP(a_front_sorted, count_q >= CNT_W'(2),
		slot_job[0].release_time <= slot_job[1].release_time, "front jobs out of order")
	`STJQ_ASSERT_NXT(a_full_refused, accept && cmd == CMD_ENQUEUE && full,
		m_tuser == STATUS_FULL && count_q == CNT_W'(QUEUE_DEPTH), "full enqueue not refused")
	`STJQ_ASSERT_NXT(a_clear_empties, accept && cmd == CMD_CLEAR,
		count_q == '0 && m_tvalid, "clear did not empty the queue")

endmodule
